>>> src/bcc_pkg.sv
// Package for the button click classifier.
// Holds the time width, click kind codes, register indexes and the config struct.
// No dependencies.
package bcc_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SHORT  = 2'd1,
        KIND_DOUBLE = 2'd2,
        KIND_LONG   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_DOUBLE   = 2'd2,
        REG_SPARE    = 2'd3
    } t_reg_idx;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST = CFG_BITS'(50);
    localparam logic [CFG_BITS-1:0] LONG_RST     = CFG_BITS'(1000);
    localparam logic [CFG_BITS-1:0] DOUBLE_RST   = CFG_BITS'(400);

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_ms;
        logic [CFG_BITS-1:0] long_press_ms;
        logic [CFG_BITS-1:0] double_click_ms;
    } t_cfg;

endpackage

>>> src/button_click_classifier.sv
// Button click classifier: one sample of level and millisecond time in, one click kind out.
// A sample is registered in the input register, then classified and written to the result
// register; one sample per cycle is sustained while results are not stalled. Result stalls
// hold the sample in the input register.
// Depends on bcc_pkg, bcc_cfg and bcc_core.
module button_click_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [0] button_level, [32:1] now_ms, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [1:0] click_kind, rest zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bcc_pkg::*;

    logic        r_in_vld;
    logic        r_in_level;
    logic [31:0] r_in_now;
    logic        r_out_vld;
    t_kind       r_out_kind;
    logic        w_adv;
    logic        w_fire;
    t_cfg        w_cfg;
    t_kind       w_kind;

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign w_fire        = r_in_vld && w_adv;
    assign s_axis_tready = !r_in_vld || w_adv;
    assign o_cfg_ready   = 1'b1;

    bcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (t_reg_idx'(i_cfg_index)),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    bcc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_level (r_in_level),
        .i_now   (t_time'(r_in_now)),
        .i_cfg   (w_cfg),
        .o_kind  (w_kind)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_level <= s_axis_tdata[0];
            r_in_now   <= s_axis_tdata[32:1];
        end
        if (w_fire) begin
            r_out_kind <= w_kind;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out_kind};

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_adv |=> r_in_vld)
        else $error("Registered sample lost during result stall.");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> m_axis_tvalid)
        else $error("Classified sample produced no result.");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && r_out_vld && !m_axis_tready))
        else $error("Input blocked without a full pipeline stall.");

endmodule

>>> src/bcc_cfg.sv
// Configuration register file of the button click classifier.
// Depends on bcc_pkg for register indexes, reset values and the config struct.
module bcc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  bcc_pkg::t_reg_idx             i_index,
    input  logic [bcc_pkg::CFG_BITS-1:0]  i_data,
    output bcc_pkg::t_cfg                 o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= DEBOUNCE_RST;
            r_cfg.long_press_ms   <= LONG_RST;
            r_cfg.double_click_ms <= DOUBLE_RST;
        end else if (i_wr) begin
            case (i_index)
                REG_DEBOUNCE: r_cfg.debounce_ms     <= i_data;
                REG_LONG:     r_cfg.long_press_ms   <= i_data;
                REG_DOUBLE:   r_cfg.double_click_ms <= i_data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/bcc_core.sv
// Debounce and click classification state with its next-state logic.
// Depends on bcc_pkg for the time type, kind codes and the config struct.
module bcc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_level,
    input  bcc_pkg::t_time i_now,
    input  bcc_pkg::t_cfg  i_cfg,
    output bcc_pkg::t_kind o_kind
);
    import bcc_pkg::*;

    logic  r_last_level;
    logic  r_pressed;
    t_time r_stable_since;
    t_time r_press_began;
    t_time r_release_at;
    logic  r_pending;

    logic  n_pressed;
    t_time n_stable_since;
    t_time n_press_began;
    t_time n_release_at;
    logic  n_pending;
    t_kind n_kind;
    logic  w_done;

    always_comb begin
        n_pressed      = r_pressed;
        n_press_began  = r_press_began;
        n_release_at   = r_release_at;
        n_pending      = r_pending;
        n_kind         = KIND_NONE;
        w_done         = 1'b0;
        n_stable_since = (i_level != r_last_level) ? i_now : r_stable_since;

        if (t_time'(i_now - n_stable_since) > t_time'(i_cfg.debounce_ms)) begin
            if (i_level && !r_pressed) begin
                n_pressed     = 1'b1;
                n_press_began = i_now;
            end
            if (!i_level && r_pressed) begin
                n_pressed = 1'b0;
                if (t_time'(i_now - r_press_began) >= t_time'(i_cfg.long_press_ms)) begin
                    n_pending = 1'b0;
                    n_kind    = KIND_LONG;
                    w_done    = 1'b1;
                end else if (r_pending) begin
                    n_pending = 1'b0;
                    n_kind    = KIND_DOUBLE;
                    w_done    = 1'b1;
                end else begin
                    n_pending    = 1'b1;
                    n_release_at = i_now;
                end
            end
        end

        if (!w_done && n_pending &&
            t_time'(i_now - n_release_at) > t_time'(i_cfg.double_click_ms)) begin
            n_pending = 1'b0;
            n_kind    = KIND_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b0;
            r_pressed      <= 1'b0;
            r_stable_since <= '0;
            r_press_began  <= '0;
            r_release_at   <= '0;
            r_pending      <= 1'b0;
        end else if (i_en) begin
            r_last_level   <= i_level;
            r_pressed      <= n_pressed;
            r_stable_since <= n_stable_since;
            r_press_began  <= n_press_began;
            r_release_at   <= n_release_at;
            r_pending      <= n_pending;
        end
    end

    assign o_kind = n_kind;

endmodule
